// ===== design/lfpp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the length-framed packet parser: sizes, codes and the
// command/status structs shared by the controller and the datapath. No dependencies.
package lfpp_pkg;

    localparam int PAYLOAD_MAX = 32;
    localparam int ADDR_W      = $clog2(PAYLOAD_MAX);
    localparam int CNT_W       = $clog2(PAYLOAD_MAX + 1);
    localparam int LEN_W       = 6;
    localparam int SEQ_W       = 32;

    localparam logic [7:0] HEADER_RESET = 8'd64;
    localparam logic [7:0] MIN_LEN      = 8'd2;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_OK         = 2'd1,
        ST_LEN_ERR    = 2'd2,
        ST_CSUM_ERR   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_CMD,
        PH_PAY,
        PH_CHK,
        PH_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_STATUS,
        OUT_EMPTY,
        OUT_RUN
    } out_sel_t;

    typedef struct packed {
        logic     sum_init;
        logic     sum_add;
        logic     load_len;
        logic     load_cmd;
        logic     store_pay;
        logic     inc_seq;
        logic     rd_start;
        logic     rd_next;
        out_sel_t out_sel;
        status_t  out_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hdr_match;
        logic len_bad;
        logic len_zero;
        logic pay_done;
        logic sum_ok;
        logic run_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/lfpp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/lfpp_ctrl.sv =====
`timescale 1ns / 1ps
// Frame controller: parse phase state machine and the payload emit run.
// Depends on lfpp_pkg.
module lfpp_ctrl
    import lfpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    // Input taken only in parse phases, and only when the output slot is free.
    assign in_stall = (state_reg == PH_EMIT) || !dp_status.out_free;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            PH_HUNT:
            begin
                if (accept && dp_status.hdr_match)
                begin
                    state_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (accept)
                begin
                    state_next = dp_status.len_bad ? PH_HUNT : PH_CMD;
                end
            end
            PH_CMD:
            begin
                if (accept)
                begin
                    state_next = dp_status.len_zero ? PH_CHK : PH_PAY;
                end
            end
            PH_PAY:
            begin
                if (accept && dp_status.pay_done)
                begin
                    state_next = PH_CHK;
                end
            end
            PH_CHK:
            begin
                if (accept)
                begin
                    if (dp_status.sum_ok && !dp_status.len_zero)
                    begin
                        state_next = PH_EMIT;
                    end
                    else
                    begin
                        state_next = PH_HUNT;
                    end
                end
            end
            PH_EMIT:
            begin
                if (dp_status.out_free && dp_status.run_last)
                begin
                    state_next = PH_HUNT;
                end
            end
            default:
            begin
                state_next = PH_HUNT;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.out_sel    = OUT_NONE;
        cmd.out_status = ST_INCOMPLETE;
        unique case (state_reg)
            PH_HUNT:
            begin
                if (accept)
                begin
                    cmd.sum_init = dp_status.hdr_match;
                    cmd.out_sel  = OUT_STATUS;
                end
            end
            PH_LEN:
            begin
                if (accept)
                begin
                    cmd.out_sel = OUT_STATUS;
                    if (dp_status.len_bad)
                    begin
                        cmd.out_status = ST_LEN_ERR;
                    end
                    else
                    begin
                        cmd.load_len = 1'b1;
                        cmd.sum_add  = 1'b1;
                    end
                end
            end
            PH_CMD:
            begin
                if (accept)
                begin
                    cmd.load_cmd = 1'b1;
                    cmd.sum_add  = 1'b1;
                    cmd.out_sel  = OUT_STATUS;
                end
            end
            PH_PAY:
            begin
                if (accept)
                begin
                    cmd.store_pay = 1'b1;
                    cmd.sum_add   = 1'b1;
                    cmd.out_sel   = OUT_STATUS;
                end
            end
            PH_CHK:
            begin
                if (accept)
                begin
                    if (!dp_status.sum_ok)
                    begin
                        cmd.out_sel    = OUT_STATUS;
                        cmd.out_status = ST_CSUM_ERR;
                    end
                    else if (dp_status.len_zero)
                    begin
                        cmd.inc_seq = 1'b1;
                        cmd.out_sel = OUT_EMPTY;
                    end
                    else
                    begin
                        // first payload read issued now, emitted from PH_EMIT once the output is free
                        cmd.inc_seq  = 1'b1;
                        cmd.rd_start = 1'b1;
                    end
                end
            end
            PH_EMIT:
            begin
                if (dp_status.out_free)
                begin
                    cmd.out_sel = OUT_RUN;
                    cmd.rd_next = !dp_status.run_last;
                end
            end
            default:
            begin
                cmd.out_sel = OUT_NONE;
            end
        endcase
    end

endmodule

// ===== design/lfpp_dp.sv =====
`timescale 1ns / 1ps
// Datapath: header register, length/command/sum/sequence registers, payload
// store and the output register. Depends on lfpp_pkg and lfpp_ram.
module lfpp_dp
    import lfpp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data,
    input  logic [7:0]        rx_byte,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        dp_status,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [7:0]        command,
    output logic [LEN_W-1:0]  frame_payload_len,
    output logic [SEQ_W-1:0]  sequence_res,
    output logic [7:0]        payload_byte,
    output logic              payload_valid,
    output logic              last
);

    logic [7:0]       header_code_reg;
    logic [CNT_W-1:0] payload_len_reg;
    logic [CNT_W-1:0] byte_count_reg;
    logic [7:0]       cmd_hold_reg;
    logic [7:0]       sum_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic [SEQ_W-1:0] frame_seq_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]       ram_rd_data;
    logic             rd_en;

    logic             out_valid_reg;
    status_t          status_reg;
    logic [7:0]       command_reg;
    logic [LEN_W-1:0] len_out_reg;
    logic [SEQ_W-1:0] seq_out_reg;
    logic [7:0]       pbyte_reg;
    logic             pvalid_reg;
    logic             last_reg;

    assign cfg_ready = 1'b1;

    assign dp_status.hdr_match = (rx_byte == header_code_reg);
    assign dp_status.len_bad   = (rx_byte < MIN_LEN) ||
                                 ({1'b0, rx_byte} > 9'(PAYLOAD_MAX + 2));
    assign dp_status.len_zero  = (payload_len_reg == '0);
    assign dp_status.pay_done  = ({1'b0, byte_count_reg} + 1'b1) >= {1'b0, payload_len_reg};
    assign dp_status.sum_ok    = (sum_reg == rx_byte);
    assign dp_status.run_last  = ((CNT_W + 1)'(rd_idx_reg) + 1'b1) == {1'b0, payload_len_reg};
    assign dp_status.out_free  = !out_valid_reg || !out_stall;

    assign rd_en   = cmd.rd_start || cmd.rd_next;
    assign rd_addr = cmd.rd_start ? '0 : ADDR_W'(rd_idx_reg + 1'b1);

    lfpp_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_MAX)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.store_pay),
        .wr_addr (byte_count_reg[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_code_reg <= HEADER_RESET;
            payload_len_reg <= '0;
            byte_count_reg  <= '0;
            cmd_hold_reg    <= '0;
            sum_reg         <= '0;
            seq_reg         <= '0;
            frame_seq_reg   <= '0;
            rd_idx_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                header_code_reg <= cfg_data;
            end
            if (cmd.sum_init)
            begin
                sum_reg <= rx_byte;
            end
            else if (cmd.sum_add)
            begin
                sum_reg <= sum_reg + rx_byte;
            end
            if (cmd.load_len)
            begin
                payload_len_reg <= CNT_W'(rx_byte - MIN_LEN);
            end
            if (cmd.load_cmd)
            begin
                cmd_hold_reg   <= rx_byte;
                byte_count_reg <= '0;
            end
            else if (cmd.store_pay)
            begin
                byte_count_reg <= byte_count_reg + 1'b1;
            end
            if (cmd.inc_seq)
            begin
                frame_seq_reg <= seq_reg;
                seq_reg       <= seq_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_idx_reg <= rd_addr;
            end
        end
    end

    // Output register: control bit resets, payload fields load on demand.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_sel != OUT_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.out_sel)
            OUT_STATUS:
            begin
                status_reg  <= cmd.out_status;
                command_reg <= '0;
                len_out_reg <= '0;
                seq_out_reg <= '0;
                pbyte_reg   <= '0;
                pvalid_reg  <= 1'b0;
                last_reg    <= 1'b1;
            end
            OUT_EMPTY:
            begin
                status_reg  <= ST_OK;
                command_reg <= cmd_hold_reg;
                len_out_reg <= '0;
                seq_out_reg <= seq_reg;
                pbyte_reg   <= '0;
                pvalid_reg  <= 1'b0;
                last_reg    <= 1'b1;
            end
            OUT_RUN:
            begin
                status_reg  <= ST_OK;
                command_reg <= cmd_hold_reg;
                len_out_reg <= LEN_W'(payload_len_reg);
                seq_out_reg <= frame_seq_reg;
                pbyte_reg   <= ram_rd_data;
                pvalid_reg  <= 1'b1;
                last_reg    <= dp_status.run_last;
            end
            default:
            begin
                status_reg <= status_reg;
            end
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign command           = command_reg;
    assign frame_payload_len = len_out_reg;
    assign sequence_res      = seq_out_reg;
    assign payload_byte      = pbyte_reg;
    assign payload_valid     = pvalid_reg;
    assign last              = last_reg;

endmodule

// ===== design/length_framed_packet_parser.sv =====
`timescale 1ns / 1ps
// Length-framed packet parser, top level.
// Frame: header, length L, command, L-2 payload bytes, 8-bit sum checksum.
// Input channel: in_valid / in_stall with rx_byte; an item moves when valid is
// high and stall low. Every input byte yields one result item, except that the
// checksum of a good frame yields one item per payload byte (one if the payload is empty).
// Output channel: out_valid / out_stall; results sit in an output register.
// Latency: a result appears the cycle after its byte is taken. The first payload
// item of a good frame is read from the payload store, whose read is registered:
// the read is issued with the checksum byte. Throughput: one byte per cycle while
// the output register drains; a good frame then adds an emit run that reads the
// payload back one entry a cycle from the payload RAM port while the output is free.
// in_stall is high during that run and while a held result is stalled.
// Config: cfg_valid / cfg_ready / cfg_data writes the header code; cfg_ready is
// always high. Reset: hunting for a header, header code 64, sequence number 0,
// output empty. No clearing pass is needed.
// Depends on lfpp_pkg, lfpp_ctrl, lfpp_dp, lfpp_ram.
module length_framed_packet_parser
    import lfpp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [7:0]        command,
    output logic [LEN_W-1:0]  frame_payload_len,
    output logic [SEQ_W-1:0]  sequence_res,
    output logic [7:0]        payload_byte,
    output logic              payload_valid,
    output logic              last
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    lfpp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    lfpp_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .rx_byte           (rx_byte),
        .cmd               (cmd),
        .dp_status         (dp_status),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .command           (command),
        .frame_payload_len (frame_payload_len),
        .sequence_res      (sequence_res),
        .payload_byte      (payload_byte),
        .payload_valid     (payload_valid),
        .last              (last)
    );

endmodule
